/* rtl/bcw_pkg.sv */
package bcw_pkg;

   localparam logic [23:0] CRC_INIT    = 24'h555555;
   localparam logic [23:0] CRC_TAPS    = 24'h00065B;
   localparam logic [7:0]  WHITEN_FB   = 8'h11;
   localparam logic [7:0]  SEED_FORCE  = 8'h02;
   localparam logic [5:0]  CHAN_RESET  = 6'd37;
   localparam int          QUEUE_DEPTH = 4;

   // Register indexes on the CSR port.
   localparam logic CSR_MODE_DECODE    = 1'b0;
   localparam logic CSR_WHITEN_CHANNEL = 1'b1;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        decode;
      logic        start;
      logic [7:0]  seed;
      logic [23:0] crc;
   } qent_type;

   typedef struct packed {
      logic [7:0] lfsr;
      logic [7:0] data;
   } whiten_type;

   function automatic logic [7:0] rev8(input logic [7:0] a);
      logic [7:0] v;
      for (int i = 0; i < 8; i++) begin
         v[7 - i] = a[i];
      end
      return v;
   endfunction

   function automatic logic [7:0] seed_of(input logic [5:0] chan);
      return rev8({2'b00, chan}) | SEED_FORCE;
   endfunction

   // Eight steps of the whitening LFSR, applied to data from bit 0 upward.
   function automatic whiten_type whiten(input logic [7:0] lfsr, input logic [7:0] b);
      whiten_type r;
      r.lfsr = lfsr;
      r.data = b;
      for (int i = 0; i < 8; i++) begin
         if (r.lfsr[7]) begin
            r.lfsr    = r.lfsr ^ WHITEN_FB;
            r.data[i] = ~r.data[i];
         end
         r.lfsr = {r.lfsr[6:0], 1'b0};
      end
      return r;
   endfunction

endpackage

/* rtl/ble_crc_whiten_codec.sv */
// Bluetooth LE byte coder: CRC-24 and data whitening, one byte per request.
// Request channel: req_valid, req_stall, req_byte, req_last. A byte is taken
// at a clock edge where req_valid is high and req_stall is low; req_last marks
// the final byte of a packet. Response channel: rsp_valid, rsp_stall, rsp_byte,
// rsp_last, with the same handshake and rsp_stall driven by the receiver.
// Configuration: csr_valid, csr_ready (always high), csr_index, csr_data.
// Index 0 selects decode mode (bit 0), index 1 the whitening channel. Write
// them only while no packet is in flight.
// The front stage updates the CRC in encode mode and pushes each accepted
// byte into a small queue; the back stage pops, whitens and loads it into the
// output register, which it owns. One byte leaves per cycle while rsp_stall
// is low, but an encoded last byte produces four response bytes (data plus
// three CRC bytes) and holds the back stage until all have left, so req_stall
// rises once the queue fills. A stalled response holds its value; the queue
// absorbs requests until it is full. Reset empties the queue and output
// register, selects encode mode and channel 37, and starts a new packet.
module ble_crc_whiten_codec #(
   parameter int QUEUE_DEPTH = bcw_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [5:0] csr_data
);
   import bcw_pkg::*;

   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_empty;
   qent_type push_data;
   qent_type pop_data;

   bcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_byte   (req_byte),
      .req_last   (req_last),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   bcw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   bcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_byte    (rsp_byte),
      .rsp_last    (rsp_last)
   );

endmodule

/* rtl/bcw_queue.sv */
module bcw_queue #(
   parameter int DEPTH = bcw_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bcw_pkg::qent_type push_data,
   output logic              full,
   input  logic              pop,
   output bcw_pkg::qent_type pop_data,
   output logic              empty
);
   import bcw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   qent_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/bcw_front.sv */
module bcw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_byte,
   input  logic              req_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [5:0]        csr_data,
   output logic              push,
   output bcw_pkg::qent_type push_data,
   input  logic              queue_full
);
   import bcw_pkg::*;

   logic        mode_ff;
   logic [5:0]  chan_ff;
   logic [23:0] crc_ff, crc_in;
   logic        in_packet_ff;
   logic        accept;
   logic        start;
   logic [23:0] crc_base;
   logic [23:0] crc_next;

   function automatic logic [23:0] crc_byte(input logic [23:0] c, input logic [7:0] d);
      logic [23:0] r;
      logic        top;
      r = c;
      for (int i = 0; i < 8; i++) begin
         top = r[23];
         r   = {r[22:0], 1'b0};
         if (top != d[i]) begin
            r = r ^ CRC_TAPS;
         end
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   assign start    = !in_packet_ff;
   assign crc_base = start ? CRC_INIT : crc_ff;
   assign crc_next = crc_byte(crc_base, req_byte);
   assign crc_in   = mode_ff ? crc_base : crc_next;

   always_comb begin
      push_data.data   = mode_ff ? rev8(req_byte) : req_byte;
      push_data.last   = req_last;
      push_data.decode = mode_ff;
      push_data.start  = start;
      push_data.seed   = seed_of(chan_ff);
      push_data.crc    = crc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         chan_ff      <= CHAN_RESET;
         crc_ff       <= CRC_INIT;
         in_packet_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MODE_DECODE: begin
                  mode_ff <= csr_data[0];
               end
               CSR_WHITEN_CHANNEL: begin
                  chan_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            crc_ff       <= crc_in;
            in_packet_ff <= !req_last;
         end
      end
   end

endmodule

/* rtl/bcw_back.sv */
module bcw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  bcw_pkg::qent_type pop_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last
);
   import bcw_pkg::*;

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [7:0]  lfsr_ff, lfsr_in;
   logic [23:0] hold_ff, hold_in;
   logic [1:0]  crc_left_ff, crc_left_in;
   logic        advance;
   logic [7:0]  lfsr_base;
   whiten_type  wd;
   whiten_type  wc;

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;

   // The output register may load whenever it is empty or being taken.
   assign advance   = !valid_ff || !rsp_stall;
   assign pop       = advance && (crc_left_ff == 2'd0) && !queue_empty;
   assign lfsr_base = pop_data.start ? pop_data.seed : lfsr_ff;
   assign wd        = whiten(lfsr_base, pop_data.data);
   assign wc        = whiten(lfsr_ff, rev8(hold_ff[23:16]));

   always_comb begin
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      lfsr_in     = lfsr_ff;
      hold_in     = hold_ff;
      crc_left_in = crc_left_ff;
      if (advance) begin
         valid_in = 1'b0;
         if (crc_left_ff != 2'd0) begin
            valid_in    = 1'b1;
            byte_in     = rev8(wc.data);
            last_in     = (crc_left_ff == 2'd1);
            lfsr_in     = wc.lfsr;
            hold_in     = {hold_ff[15:0], 8'h00};
            crc_left_in = crc_left_ff - 2'd1;
         end else if (!queue_empty) begin
            valid_in = 1'b1;
            lfsr_in  = wd.lfsr;
            if (pop_data.decode) begin
               byte_in = wd.data;
               last_in = pop_data.last;
            end else begin
               byte_in = rev8(wd.data);
               last_in = 1'b0;
               if (pop_data.last) begin
                  hold_in     = pop_data.crc;
                  crc_left_in = 2'd3;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         crc_left_ff <= 2'd0;
      end else begin
         valid_ff    <= valid_in;
         crc_left_ff <= crc_left_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      lfsr_ff <= lfsr_in;
      hold_ff <= hold_in;
   end

endmodule

/* rtl/bcw_checker.sv */
module bcw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_byte,
   input logic       rsp_last
);

   // After reset the output register is empty and the queue is not full.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("stalled response changed");

   // Once an accepted request has passed the queue into the output register, a response is valid: its own or one ahead.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("no response after accepted request");

endmodule

bind ble_crc_whiten_codec bcw_checker u_bcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_byte  (rsp_byte),
   .rsp_last  (rsp_last)
);

/* dv/ble_crc_whiten_codec_check.sv */
`timescale 1ns / 100ps

module ble_crc_whiten_codec_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_byte,
   input  logic       rsp_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_index,
   input  logic [5:0] csr_data,
   output int         fail_count,
   output int         bytes_due,
   output int         bytes_checked
);
   import bcw_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } radio_byte_type;

   radio_byte_type radio_bytes_due[$];
   radio_byte_type got_byte;
   radio_byte_type due_byte;

   // Shadow copy of the block's registers and coding state.
   logic        decode_mode;
   logic [5:0]  chan_sel;
   logic [23:0] crc_acc;
   logic [7:0]  scrambler;
   logic        mid_packet;

   initial begin
      fail_count    = 0;
      bytes_due     = 0;
      bytes_checked = 0;
   end

   function automatic logic [7:0] flip8(input logic [7:0] a);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = a[7 - i];
      end
      return r;
   endfunction

   // Advances the shadow whitening register by one byte.
   function automatic logic [7:0] scramble(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      for (int i = 0; i < 8; i++) begin
         if (scrambler[7]) begin
            scrambler = scrambler ^ WHITEN_FB;
            r[i] = ~r[i];
         end
         scrambler = {scrambler[6:0], 1'b0};
      end
      return r;
   endfunction

   task automatic crc_feed(input logic [7:0] d);
      logic top;
      for (int i = 0; i < 8; i++) begin
         top = crc_acc[23];
         crc_acc = {crc_acc[22:0], 1'b0};
         if (top != d[i]) begin
            crc_acc = crc_acc ^ CRC_TAPS;
         end
      end
   endtask

   task automatic predict_coding(input logic [7:0] b, input logic last);
      radio_byte_type e;
      logic [7:0]     c;
      if (!mid_packet) begin
         crc_acc   = CRC_INIT;
         scrambler = flip8({2'b00, chan_sel}) | SEED_FORCE;
      end
      mid_packet = !last;
      if (decode_mode) begin
         e.data = scramble(flip8(b));
         e.last = last;
         radio_bytes_due.push_back(e);
      end else begin
         crc_feed(b);
         e.data = flip8(scramble(b));
         e.last = 1'b0;
         radio_bytes_due.push_back(e);
         if (last) begin
            // The CRC goes out high byte first, each byte sent MSB first.
            for (int k = 0; k < 3; k++) begin
               c = crc_acc[23 - 8 * k -: 8];
               e.data = flip8(scramble(flip8(c)));
               e.last = (k == 2);
               radio_bytes_due.push_back(e);
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         decode_mode = 1'b0;
         chan_sel    = CHAN_RESET;
         crc_acc     = CRC_INIT;
         scrambler   = flip8({2'b00, CHAN_RESET}) | SEED_FORCE;
         mid_packet  = 1'b0;
         radio_bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE_DECODE: begin
                  decode_mode = csr_data[0];
               end
               CSR_WHITEN_CHANNEL: begin
                  chan_sel = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            bytes_checked++;
            got_byte.data = rsp_byte;
            got_byte.last = rsp_last;
            if (radio_bytes_due.size() == 0) begin
               report_mismatch($sformatf("response %02h/%0b with nothing expected",
                                         got_byte.data, got_byte.last));
            end else begin
               due_byte = radio_bytes_due.pop_front();
               if (got_byte.data !== due_byte.data) begin
                  report_mismatch($sformatf("rsp_byte %02h, expected %02h",
                                            got_byte.data, due_byte.data));
               end
               if (got_byte.last !== due_byte.last) begin
                  report_mismatch($sformatf("rsp_last %0b, expected %0b (byte %02h)",
                                            got_byte.last, due_byte.last, due_byte.data));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_coding(req_byte, req_last);
         end
      end
      bytes_due = radio_bytes_due.size();
   end

endmodule

/* dv/ble_crc_whiten_codec_test.sv */
`timescale 1ns / 100ps

module ble_crc_whiten_codec_test;
   import bcw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_byte;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [5:0] csr_data;

   int fail_count;
   int bytes_due;
   int bytes_checked;
   int cycle_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int sent_bytes = 0;
   int sent_packets = 0;

   ble_crc_whiten_codec dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ble_crc_whiten_codec_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_byte      (req_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_byte      (rsp_byte),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .bytes_due     (bytes_due),
      .bytes_checked (bytes_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte  <= b;
      req_last  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_bytes++;
      if (last) begin
         sent_packets++;
      end
   endtask

   // Holds off new requests until every predicted response byte has arrived.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (bytes_due != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_reg(input logic idx, input logic [5:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic decode, input logic [5:0] chan);
      write_reg(CSR_MODE_DECODE, {5'b00000, decode});
      write_reg(CSR_WHITEN_CHANNEL, chan);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_packet(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(pick_byte(), i == len - 1);
      end
   endtask

   initial begin
      int         phase_start;
      int         len;
      logic [5:0] chan;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_byte  <= 8'h00;
      req_last  <= 1'b0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MODE_DECODE;
      csr_data  <= 6'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: encode on channel 37.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hA5, 1'b1);
      drain();
      set_config(1'b0, 6'd0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain();
      set_config(1'b0, 6'd39);
      send_byte(8'h01, 1'b1);
      drain();
      // Channels above 39 still seed the whitener by the same rule.
      set_config(1'b0, 6'd63);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      drain();
      set_config(1'b0, 6'd40);
      send_byte(8'h3C, 1'b1);
      drain();
      set_config(1'b1, 6'd37);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5A, 1'b1);
      drain();
      set_config(1'b1, 6'd63);
      send_byte(8'h81, 1'b1);
      drain();
      set_config(1'b0, CHAN_RESET);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 28;
               rx_idle_pct <= 58;
            end
            1: begin
               tx_idle_pct = 58;
               rx_idle_pct <= 28;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
            end
         endcase
         phase_start = sent_bytes;
         while (sent_bytes - phase_start < 45) begin
            if ($urandom_range(4) == 0) begin
               drain();
               case ($urandom_range(9))
                  0: chan = 6'd0;
                  1: chan = 6'd39;
                  2: chan = 6'($urandom_range(40, 63));
                  default: chan = 6'($urandom_range(39));
               endcase
               set_config(1'($urandom_range(1)), chan);
            end else if ($urandom_range(19) == 0) begin
               drain();
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 5);
            send_packet(len);
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (bytes_due != 0) @(negedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d request bytes in %0d packets, encode and decode, channels 0 to 63.",
               sent_bytes, sent_packets);
      $display("Compared %0d response bytes under three stall mixes.", bytes_checked);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
